/* src/arpc_pkg.sv */
// Shared types and constants of the ARP responder with address cache.
// Used by the controller, the datapath and the top level; no dependencies.
package arpc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP = 1'd0;
  // index 1 (own MAC) is accepted but not stored: the frame builder fills in our MAC

  // item kinds
  localparam logic [1:0] ACT_RX      = 2'd0;
  localparam logic [1:0] ACT_RESOLVE = 2'd1;
  localparam logic [1:0] ACT_STORE   = 2'd2;

  // ARP header values, network order normalized
  localparam logic [10:0] ARP_MIN_LEN     = 11'd28;
  localparam logic [15:0] ARP_HTYPE_ETH   = 16'h0001;
  localparam logic [15:0] ARP_PTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  ARP_HLEN_ETH    = 8'd6;
  localparam logic [7:0]  ARP_PLEN_IPV4   = 8'd4;
  localparam logic [15:0] ARP_OP_REQUEST  = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY    = 16'd2;

  // result kinds and transmit opcodes
  localparam logic [1:0] RES_NONE    = 2'd0;
  localparam logic [1:0] RES_REPLY   = 2'd1;
  localparam logic [1:0] RES_REQUEST = 2'd2;
  localparam logic [1:0] RES_HIT     = 2'd3;
  localparam logic [1:0] TXOP_NONE    = 2'd0;
  localparam logic [1:0] TXOP_REQUEST = 2'd1;
  localparam logic [1:0] TXOP_REPLY   = 2'd2;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [10:0] payload_length;
    logic [15:0] hardware_type;
    logic [15:0] protocol_type;
    logic [7:0]  hw_addr_len;
    logic [7:0]  proto_addr_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } arpc_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  tx_opcode;
    logic [47:0] tx_dest_mac;
    logic [31:0] tx_dest_ip;
    logic [47:0] resolved_mac;
  } arpc_out_t;

  // work decoded from one transaction
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_REPLY  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_INSERT = 2'd3
  } arpc_op_e;

  typedef struct packed {
    logic load;    // latch item, clear scan trackers
    logic issue;   // read entry at scan address, advance
    logic finish;  // update cache, register result
  } arpc_cmd_t;

  typedef struct packed {
    logic need_scan;  // decoded from the item at the input
    logic scan_last;  // scan address is the last entry
  } arpc_status_t;

endpackage

/* src/arpc_ctrl.sv */
// Controller of the ARP cache: sequences load, cache scan and finish.
// Depends on arpc_pkg for the command and status structs.
module arpc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  arpc_pkg::arpc_status_t   status_i,
  output arpc_pkg::arpc_cmd_t      cmd_o
);
  import arpc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } arpc_state_e;

  arpc_state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.need_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last read entry is compared here
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_scan_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && status_i.scan_last) |=> !cmd_o.issue)
    else $error("scan ran past the last entry");
`endif

endmodule

/* src/arpc_dp.sv */
// Datapath of the ARP cache: item decode, cache memory, scan compare,
// insert slot selection and result register. Depends on arpc_pkg.
module arpc_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  arpc_pkg::arpc_in_t           in_i,
  input  logic                         cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  arpc_pkg::arpc_cmd_t          cmd_i,
  output arpc_pkg::arpc_status_t       status_o,
  output logic                         res_valid_o,
  output arpc_pkg::arpc_out_t          res_o
);
  import arpc_pkg::*;

  localparam logic [IDX_W-1:0] ENTRY_LAST = IDX_W'(CACHE_ENTRIES - 1);

  logic [31:0]              own_ip_q;
  arpc_in_t                 item_q;
  arpc_op_e                 op_q, op_d;
  logic [31:0]              key_q;
  logic [IDX_W-1:0]         scan_q;
  logic                     cmp_vld_q;
  logic [IDX_W-1:0]         cmp_idx_q;
  logic [31:0]              ip_rd_q;
  logic [47:0]              mac_rd_q;
  logic                     found_q;
  logic [IDX_W-1:0]         found_idx_q;
  logic [47:0]              found_mac_q;
  logic                     free_q;
  logic [IDX_W-1:0]         free_idx_q;
  logic [CACHE_ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0]         rp_q;
  logic                     res_valid_q;
  arpc_out_t                res_q, res_d;

  logic [31:0] ip_mem  [CACHE_ENTRIES];
  logic [47:0] mac_mem [CACHE_ENTRIES];

  logic             rx_ok;
  logic             hit_c, free_c;
  logic             wr_en;
  logic [IDX_W-1:0] slot_c;

  // decode of the item at the input, used on load
  assign rx_ok = (in_i.payload_length >= ARP_MIN_LEN) &&
                 (in_i.hardware_type == ARP_HTYPE_ETH) &&
                 (in_i.protocol_type == ARP_PTYPE_IPV4) &&
                 (in_i.hw_addr_len == ARP_HLEN_ETH) &&
                 (in_i.proto_addr_len == ARP_PLEN_IPV4) &&
                 (in_i.target_ip == own_ip_q);

  always_comb begin
    op_d = OP_NONE;
    case (in_i.action)
      ACT_RX: begin
        if (rx_ok && in_i.opcode == ARP_OP_REPLY) begin
          op_d = OP_INSERT;
        end else if (rx_ok && in_i.opcode == ARP_OP_REQUEST) begin
          op_d = OP_REPLY;
        end
      end
      ACT_RESOLVE: op_d = OP_QUERY;
      ACT_STORE:   op_d = OP_INSERT;
      default:     op_d = OP_NONE;
    endcase
  end

  assign status_o.need_scan = (op_d == OP_QUERY) || (op_d == OP_INSERT);
  assign status_o.scan_last = (scan_q == ENTRY_LAST);

  // compare stage, one entry behind the read address
  assign hit_c  = cmp_vld_q && valid_q[cmp_idx_q] && (ip_rd_q == key_q);
  assign free_c = cmp_vld_q && !valid_q[cmp_idx_q];

  // known IP first, then lowest free entry, then round-robin victim
  assign slot_c = found_q ? found_idx_q : (free_q ? free_idx_q : rp_q);
  assign wr_en  = cmd_i.finish && (op_q == OP_INSERT);

  always_comb begin
    res_d = '0;
    case (op_q)
      OP_REPLY: begin
        res_d.result_kind = RES_REPLY;
        res_d.tx_opcode   = TXOP_REPLY;
        res_d.tx_dest_mac = item_q.sender_mac;
        res_d.tx_dest_ip  = item_q.sender_ip;
      end
      OP_QUERY: begin
        if (found_q) begin
          res_d.result_kind  = RES_HIT;
          res_d.resolved_mac = found_mac_q;
        end else begin
          res_d.result_kind = RES_REQUEST;
          res_d.tx_opcode   = TXOP_REQUEST;
          res_d.tx_dest_mac = BCAST_MAC;
          res_d.tx_dest_ip  = item_q.query_ip;
        end
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q    <= '0;
      op_q        <= OP_NONE;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      rp_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_OWN_IP) begin
        own_ip_q <= cfg_data_i[31:0];
      end
      cmp_vld_q   <= cmd_i.issue;
      res_valid_q <= cmd_i.finish;
      if (cmd_i.load) begin
        op_q    <= op_d;
        scan_q  <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          scan_q <= scan_q + 1'b1;
        end
        if (hit_c && !found_q) begin
          found_q <= 1'b1;
        end
        if (free_c && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (wr_en) begin
        valid_q[slot_c] <= 1'b1;
        if (!found_q && !free_q) begin
          rp_q <= (rp_q == ENTRY_LAST) ? '0 : rp_q + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_i;
      key_q  <= (in_i.action == ACT_RESOLVE) ? in_i.query_ip : in_i.sender_ip;
    end
    cmp_idx_q <= scan_q;
    if (hit_c && !found_q) begin
      found_idx_q <= cmp_idx_q;
      found_mac_q <= mac_rd_q;
    end
    if (free_c && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  // cache memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ip_mem[slot_c]  <= key_q;
      mac_mem[slot_c] <= item_q.sender_mac;
    end
    if (cmd_i.issue) begin
      ip_rd_q  <= ip_mem[scan_q];
      mac_rd_q <= mac_mem[scan_q];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_strobe_follows_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> res_valid_o)
    else $error("finish did not produce a result strobe");
  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> valid_q[found_idx_q])
    else $error("recorded hit on an invalid entry");
  a_rp_only_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en |=> $stable(rp_q))
    else $error("replace pointer moved without an insert");
`endif

endmodule

/* src/arp_responder_cache_top.sv */
// ARP responder with IPv4-to-MAC address cache, top level.
// Joins arpc_ctrl and arpc_dp; depends on arpc_pkg.
//
// Usage: present an item on in_i with start high while busy is low. A resolve
// query or a cache store (also a received ARP reply that is learned) scans all
// CACHE_ENTRIES entries through the cache's single read port, one per cycle,
// then passes the drain and finish states; busy stays high until its result
// strobes. Other items (received requests, rejected payloads) go from load
// straight to the finish state. Every item gives exactly one result, held on
// res_o for one cycle with res_valid_o high; the receiver cannot stall it, so
// it must take each result in that cycle. Configuration is to be written by
// the user only while busy is low; the block itself does not enforce it. The
// cache needs no clearing pass after reset.
module arp_responder_cache_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  arpc_pkg::arpc_in_t              in_i,
  input  logic                            cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            res_valid_o,
  output arpc_pkg::arpc_out_t             res_o
);
  import arpc_pkg::*;

  arpc_cmd_t    cmd;
  arpc_status_t status;

  arpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  arpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
